// ===== rtl/core/cdg_pkg.sv =====
// Shared types and constants for the CSV delimiter guesser.
// Depends on nothing; every other file of the block refers to it by scoped names.
`default_nettype none

package cdg_pkg;

	localparam int NUM_CAND = 5;
	localparam int CAND_IDX_W = 3;
	localparam int SCORE_W = 2;
	localparam int LINES_W = 4;

	typedef logic [CAND_IDX_W-1:0] cand_idx_t;
	typedef logic [SCORE_W-1:0] score_t;
	typedef logic [LINES_W-1:0] lines_t;
	typedef logic [7:0] byte_t;

	localparam byte_t NEWLINE_BYTE = 8'd10;
	localparam score_t START_SCORE = 2'd2;
	localparam score_t ABSENT_SCORE = 2'd1;
	localparam score_t MISMATCH_SCORE = 2'd0;
	localparam lines_t LINES_MAX = {LINES_W{1'b1}};
	localparam lines_t LOOKAHEAD_RESET = 4'd5;

	localparam byte_t CAND_CHAR [NUM_CAND] = '{8'h7C, 8'h3B, 8'h2C, 8'h09, 8'h20};

	// One request handed from the input stage to the tracker.
	typedef struct packed {
		logic  valid;
		logic  end_mark;
		byte_t text_byte;
	} step_t;

	function automatic byte_t cand_char_of(input cand_idx_t idx);
		byte_t ch;
		ch = CAND_CHAR[0];
		for (int i = 0; i < NUM_CAND; i++) begin
			if (idx == cand_idx_t'(i)) begin
				ch = CAND_CHAR[i];
			end
		end
		return ch;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/cdg_in_if.sv =====
// Input channel of the delimiter guesser: one text byte and an end mark per request.
// Uses cdg_pkg for the byte type.
`default_nettype none

interface cdg_in_if;
	logic            valid;
	logic            ready;
	cdg_pkg::byte_t  text_byte;
	logic            end_of_sample;

	modport source (output valid, output text_byte, output end_of_sample, input ready);
	modport sink (input valid, input text_byte, input end_of_sample, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/cdg_out_if.sv =====
// Output channel of the delimiter guesser: the chosen delimiter and its index.
// Uses cdg_pkg for the byte and index types.
`default_nettype none

interface cdg_out_if;
	logic               valid;
	logic               ready;
	cdg_pkg::byte_t     guessed_delimiter;
	cdg_pkg::cand_idx_t candidate_index;

	modport source (output valid, output guessed_delimiter, output candidate_index, input ready);
	modport sink (input valid, input guessed_delimiter, input candidate_index, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/cdg_tracker.sv =====
// Per-candidate line counters, first-line counts and scores, with the winner select.
// Depends on cdg_pkg for the step struct, candidate table and score codes.
`default_nettype none

module cdg_tracker #(
	parameter int COUNT_WIDTH = 16
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire cdg_pkg::step_t      step,
	input  wire cdg_pkg::lines_t     lookahead,
	output cdg_pkg::cand_idx_t       winner
);

	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

	logic [COUNT_WIDTH-1:0] first_cnt_q [cdg_pkg::NUM_CAND];
	logic [COUNT_WIDTH-1:0] cur_cnt_q [cdg_pkg::NUM_CAND];
	cdg_pkg::score_t        score_q [cdg_pkg::NUM_CAND];
	cdg_pkg::score_t        score_close [cdg_pkg::NUM_CAND];
	cdg_pkg::score_t        score_eff [cdg_pkg::NUM_CAND];
	cdg_pkg::lines_t        lines_q;

	logic active;
	logic is_newline;
	logic do_close;
	logic do_count;
	logic first_line;

	assign active     = lines_q < lookahead;
	assign is_newline = step.text_byte == cdg_pkg::NEWLINE_BYTE;
	assign do_close   = step.valid && active && (step.end_mark || is_newline);
	assign do_count   = step.valid && active && !step.end_mark && !is_newline;
	assign first_line = lines_q == '0;

	always_comb begin
		for (int i = 0; i < cdg_pkg::NUM_CAND; i++) begin
			score_close[i] = score_q[i];
			if (first_line) begin
				if (cur_cnt_q[i] == '0) begin
					score_close[i] = cdg_pkg::ABSENT_SCORE;
				end
			end else if (cur_cnt_q[i] != first_cnt_q[i]) begin
				score_close[i] = cdg_pkg::MISMATCH_SCORE;
			end
			score_eff[i] = do_close ? score_close[i] : score_q[i];
		end
	end

	// The earlier candidate keeps the lead on a tie.
	always_comb begin
		cdg_pkg::score_t best_score;
		best_score = score_eff[0];
		winner = '0;
		for (int i = 1; i < cdg_pkg::NUM_CAND; i++) begin
			if (score_eff[i] > best_score) begin
				best_score = score_eff[i];
				winner = cdg_pkg::cand_idx_t'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lines_q <= '0;
			for (int i = 0; i < cdg_pkg::NUM_CAND; i++) begin
				first_cnt_q[i] <= '0;
				cur_cnt_q[i] <= '0;
				score_q[i] <= cdg_pkg::START_SCORE;
			end
		end else if (step.valid && step.end_mark) begin
			lines_q <= '0;
			for (int i = 0; i < cdg_pkg::NUM_CAND; i++) begin
				first_cnt_q[i] <= '0;
				cur_cnt_q[i] <= '0;
				score_q[i] <= cdg_pkg::START_SCORE;
			end
		end else if (do_close) begin
			if (lines_q != cdg_pkg::LINES_MAX) begin
				lines_q <= lines_q + 1'b1;
			end
			for (int i = 0; i < cdg_pkg::NUM_CAND; i++) begin
				if (first_line) begin
					first_cnt_q[i] <= cur_cnt_q[i];
				end
				cur_cnt_q[i] <= '0;
				score_q[i] <= score_close[i];
			end
		end else if (do_count) begin
			for (int i = 0; i < cdg_pkg::NUM_CAND; i++) begin
				if (step.text_byte == cdg_pkg::CAND_CHAR[i] && cur_cnt_q[i] != COUNT_MAX) begin
					cur_cnt_q[i] <= cur_cnt_q[i] + 1'b1;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/csv_delimiter_guesser.sv =====
// Top level of the CSV delimiter guesser: input stage, tracker and result register.
// Depends on cdg_pkg, cdg_in_if, cdg_out_if and cdg_tracker.
//
// Usage: text bytes arrive on the sample channel, one request per byte, with
// end_of_sample set on a closing request whose byte is ignored. Each closing
// request yields one result on the guess channel: the delimiter character and
// its candidate index. Other requests yield nothing.
// The lookahead register (lookahead_q) is written through cfg_we and cfg_wdata;
// the user must write it only while the block is idle, as the block does not
// enforce this. It resets to 5. Throughput is one request per cycle, except
// while a closing request waits as described below. A request in the input
// stage is processed by the tracker as it advances, and a closing request's
// result is captured in the result register and shown on the guess channel
// from there. The tracker has five parallel compare-and-increment counters.
// When the receiver stalls, the result register holds its value; ordinary
// bytes keep flowing, and only a second closing request waits in the input
// stage until the pending result is taken.
// Reset clears the input stage valid and result valid, sets all scores to two,
// clears all counts and restores the lookahead to 5.
`default_nettype none

module csv_delimiter_guesser #(
	parameter int COUNT_WIDTH = 16
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              cfg_we,
	input  wire  [3:0]       cfg_wdata,
	cdg_in_if.sink           sample,
	cdg_out_if.source        guess
);

	logic                valid_s1;
	logic                end_s1;
	cdg_pkg::byte_t      byte_s1;
	cdg_pkg::lines_t     lookahead_q;
	logic                out_valid_q;
	cdg_pkg::byte_t      out_char_q;
	cdg_pkg::cand_idx_t  out_idx_q;
	cdg_pkg::cand_idx_t  winner;
	cdg_pkg::step_t      step;
	logic                advance;

	assign advance = valid_s1 && !(end_s1 && out_valid_q && !guess.ready);
	assign sample.ready = !valid_s1 || advance;

	assign step.valid     = advance;
	assign step.end_mark  = end_s1;
	assign step.text_byte = byte_s1;

	cdg_tracker #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_tracker (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.lookahead (lookahead_q),
		.winner    (winner)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lookahead_q <= cdg_pkg::LOOKAHEAD_RESET;
		end else if (cfg_we) begin
			lookahead_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.ready) begin
			byte_s1 <= sample.text_byte;
			end_s1 <= sample.end_of_sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && end_s1) begin
			out_valid_q <= 1'b1;
		end else if (guess.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && end_s1) begin
			out_char_q <= cdg_pkg::cand_char_of(winner);
			out_idx_q <= winner;
		end
	end

	assign guess.valid             = out_valid_q;
	assign guess.guessed_delimiter = out_char_q;
	assign guess.candidate_index   = out_idx_q;

	a_result_follows_close: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && end_s1) |=> (out_valid_q && out_idx_q == $past(winner)))
		else $error("closing request did not produce its result");

	a_pending_result_blocks_close: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && end_s1 && out_valid_q && !guess.ready) |-> !sample.ready)
		else $error("closing request advanced over a stalled result");

	a_result_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_idx_q < 3'd5 && out_char_q == cdg_pkg::cand_char_of(out_idx_q)))
		else $error("result index and delimiter disagree");

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for csv_delimiter_guesser: streams text requests, predicts each guess.
// Depends on cdg_pkg, cdg_in_if, cdg_out_if and the csv_delimiter_guesser RTL.

module tb;

	localparam int COUNT_WIDTH = 16;
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
	localparam int MAX_IDLE = 14;
	localparam int RAND_ITEMS = 880;
	localparam int PHASE_ITEMS = 100;
	localparam int STALL_LIMIT = 1000;
	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic           eos;
		cdg_pkg::byte_t b;
	} text_req_t;

	typedef struct packed {
		cdg_pkg::byte_t     delim;
		cdg_pkg::cand_idx_t idx;
	} guess_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [3:0] cfg_wdata = 4'd0;
	logic req_valid = 1'b0;
	cdg_pkg::byte_t req_byte = 8'd0;
	logic req_eos = 1'b0;
	logic rsp_ready = 1'b0;

	cdg_in_if text_if ();
	cdg_out_if guess_if ();

	assign text_if.valid = req_valid;
	assign text_if.text_byte = req_byte;
	assign text_if.end_of_sample = req_eos;
	assign guess_if.ready = rsp_ready;

	csv_delimiter_guesser #(.COUNT_WIDTH(COUNT_WIDTH)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.sample(text_if),
		.guess(guess_if)
	);

	text_req_t pending_q [$];
	guess_t guess_q [$];
	int sent_cnt = 0;
	int sent_ends = 0;
	int accepted_cnt = 0;
	int checked_cnt = 0;
	int bad_cnt = 0;
	int quiet_cycles = 0;
	int gap_left = 0;
	int stall_left = 0;
	int max_gap = MAX_IDLE;
	int max_stall = MAX_IDLE;
	int wins [cdg_pkg::NUM_CAND];
	int lookahead_writes = 0;

	logic [COUNT_WIDTH-1:0] first_cnt [cdg_pkg::NUM_CAND];
	logic [COUNT_WIDTH-1:0] line_cnt [cdg_pkg::NUM_CAND];
	cdg_pkg::score_t score [cdg_pkg::NUM_CAND];
	cdg_pkg::lines_t closed_lines;
	cdg_pkg::lines_t lookahead;

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic void clear_sample_state();
		for (int c = 0; c < cdg_pkg::NUM_CAND; c++) begin
			first_cnt[c] = '0;
			line_cnt[c] = '0;
			score[c] = cdg_pkg::START_SCORE;
		end
		closed_lines = '0;
	endfunction

	function automatic void close_text_line();
		for (int c = 0; c < cdg_pkg::NUM_CAND; c++) begin
			if (closed_lines == '0) begin
				first_cnt[c] = line_cnt[c];
				if (line_cnt[c] == '0) begin
					score[c] = cdg_pkg::ABSENT_SCORE;
				end
			end else if (line_cnt[c] != first_cnt[c]) begin
				score[c] = cdg_pkg::MISMATCH_SCORE;
			end
			line_cnt[c] = '0;
		end
		if (closed_lines != cdg_pkg::LINES_MAX) begin
			closed_lines = closed_lines + 1'b1;
		end
	endfunction

	function automatic void track_request(input cdg_pkg::byte_t b, input logic eos);
		logic active;
		int best;
		guess_t g;
		active = closed_lines < lookahead;
		if (eos) begin
			if (active) begin
				close_text_line();
			end
			best = 0;
			for (int c = 1; c < cdg_pkg::NUM_CAND; c++) begin
				if (score[c] > score[best]) begin
					best = c;
				end
			end
			g.delim = cdg_pkg::CAND_CHAR[best];
			g.idx = cdg_pkg::cand_idx_t'(best);
			guess_q.push_back(g);
			wins[best]++;
			clear_sample_state();
		end else if (active) begin
			if (b == cdg_pkg::NEWLINE_BYTE) begin
				close_text_line();
			end else begin
				for (int c = 0; c < cdg_pkg::NUM_CAND; c++) begin
					if (b == cdg_pkg::CAND_CHAR[c] && line_cnt[c] != COUNT_MAX) begin
						line_cnt[c] = line_cnt[c] + 1'b1;
					end
				end
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		text_req_t nxt;
		if (!arst_n) begin
			req_valid <= 1'b0;
			req_byte <= 8'd0;
			req_eos <= 1'b0;
			gap_left = 0;
		end else begin
			if (req_valid && text_if.ready) begin
				track_request(req_byte, req_eos);
				accepted_cnt++;
			end
			if (!req_valid || text_if.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					req_valid <= 1'b0;
				end else if (pending_q.size() > 0) begin
					nxt = pending_q.pop_front();
					req_valid <= 1'b1;
					req_byte <= nxt.b;
					req_eos <= nxt.eos;
					gap_left = $urandom_range(0, max_gap);
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		guess_t want;
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			stall_left = 0;
		end else if (guess_if.valid && rsp_ready) begin
			if (guess_q.size() == 0) begin
				bad_cnt++;
				if (bad_cnt <= REPORT_LIMIT) begin
					$display("error: guess %02h index %0d arrived with none pending",
						guess_if.guessed_delimiter, guess_if.candidate_index);
				end
			end else begin
				want = guess_q.pop_front();
				checked_cnt++;
				if (guess_if.guessed_delimiter !== want.delim ||
				    guess_if.candidate_index !== want.idx) begin
					bad_cnt++;
					if (bad_cnt <= REPORT_LIMIT) begin
						$display("error: guess %0d expected delimiter %02h index %0d, got %02h index %0d",
							checked_cnt, want.delim, want.idx,
							guess_if.guessed_delimiter, guess_if.candidate_index);
					end
				end
			end
			stall_left = $urandom_range(0, max_stall);
			if (stall_left != 0) begin
				rsp_ready <= 1'b0;
			end
		end else if (!rsp_ready) begin
			if (stall_left <= 1) begin
				rsp_ready <= 1'b1;
			end
			if (stall_left > 0) begin
				stall_left--;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((req_valid && text_if.ready) || (guess_if.valid && rsp_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog: no request moved for %0d cycles", quiet_cycles);
			$display("FAILED: results differ");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic push_byte(input cdg_pkg::byte_t b, input logic eos);
		text_req_t r;
		r.b = b;
		r.eos = eos;
		pending_q.push_back(r);
		sent_cnt++;
		if (eos) begin
			sent_ends++;
		end
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			push_byte(cdg_pkg::byte_t'(s[i]), 1'b0);
		end
	endtask

	function automatic cdg_pkg::byte_t filler_byte();
		cdg_pkg::byte_t b;
		logic clash;
		do begin
			b = cdg_pkg::byte_t'($urandom_range(0, 255));
			clash = (b == cdg_pkg::NEWLINE_BYTE);
			for (int c = 0; c < cdg_pkg::NUM_CAND; c++) begin
				if (b == cdg_pkg::CAND_CHAR[c]) begin
					clash = 1'b1;
				end
			end
		end while (clash);
		return b;
	endfunction

	// Rows share one delimiter pattern; a ragged table perturbs some rows.
	task automatic push_table(input int n_lines, input bit ragged);
		int base [cdg_pkg::NUM_CAND];
		int main_c;
		int cnt;
		int pick;
		cdg_pkg::byte_t bag [$];
		main_c = $urandom_range(0, cdg_pkg::NUM_CAND - 1);
		for (int c = 0; c < cdg_pkg::NUM_CAND; c++) begin
			if (c == main_c) begin
				base[c] = $urandom_range(1, 4);
			end else if ($urandom_range(0, 2) == 0) begin
				base[c] = $urandom_range(0, 2);
			end else begin
				base[c] = 0;
			end
		end
		for (int l = 0; l < n_lines; l++) begin
			bag.delete();
			for (int c = 0; c < cdg_pkg::NUM_CAND; c++) begin
				cnt = base[c];
				if (ragged && $urandom_range(0, 3) == 0) begin
					cnt = $urandom_range(0, 4);
				end
				repeat (cnt) bag.push_back(cdg_pkg::CAND_CHAR[c]);
			end
			repeat ($urandom_range(0, 2)) push_byte(filler_byte(), 1'b0);
			while (bag.size() > 0) begin
				pick = $urandom_range(0, bag.size() - 1);
				push_byte(bag[pick], 1'b0);
				bag.delete(pick);
				repeat ($urandom_range(0, 2)) push_byte(filler_byte(), 1'b0);
			end
			if (l < n_lines - 1 || $urandom_range(0, 1) == 1) begin
				push_byte(cdg_pkg::NEWLINE_BYTE, 1'b0);
			end
		end
		push_byte(cdg_pkg::byte_t'($urandom_range(0, 255)), 1'b1);
	endtask

	task automatic push_noise(input int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 7) == 0) begin
				push_byte(cdg_pkg::NEWLINE_BYTE, 1'b0);
			end else begin
				push_byte(cdg_pkg::byte_t'($urandom_range(0, 255)), 1'b0);
			end
		end
		push_byte(cdg_pkg::byte_t'($urandom_range(0, 255)), 1'b1);
	endtask

	task automatic wait_idle();
		while (sent_cnt != accepted_cnt || guess_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic write_lookahead(input cdg_pkg::lines_t v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		lookahead = v;
		lookahead_writes++;
	endtask

	initial begin
		cdg_pkg::lines_t plan [8];
		int p;
		int rand_start;
		int phase_start;
		int kind;
		plan = '{4'd15, 4'd3, 4'd1, 4'd5, 4'd0, 4'd9, 4'd2, 4'd12};
		foreach (wins[c]) wins[c] = 0;
		clear_sample_state();
		lookahead = cdg_pkg::LOOKAHEAD_RESET;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Reset lookahead: empty sample, ignored end bytes, final line closed by the end mark.
		push_byte(8'hFF, 1'b1);
		push_byte(cdg_pkg::NEWLINE_BYTE, 1'b1);
		push_text("a,b\nc,d");
		push_byte(8'h00, 1'b1);
		push_byte(8'h00, 1'b0);
		push_text("|;,\t ");
		push_byte(8'hFF, 1'b0);
		push_byte(8'h00, 1'b1);
		push_text("a\tb\nc\td");
		push_byte(8'h00, 1'b1);
		push_text("a\tb\n");
		push_byte(8'h00, 1'b1);
		wait_idle();
		write_lookahead(4'd0);
		push_text("a;b\n");
		push_byte(8'h00, 1'b1);
		wait_idle();
		write_lookahead(4'd1);
		push_text("x;y\nx;y;z;w");
		push_byte(8'h00, 1'b1);
		wait_idle();
		write_lookahead(4'd2);
		push_text("a b\nc d\nx");
		push_byte(8'h00, 1'b1);
		wait_idle();

		rand_start = sent_cnt;
		p = 0;
		while (sent_cnt - rand_start < RAND_ITEMS) begin
			wait_idle();
			write_lookahead(plan[p % 8]);
			p++;
			phase_start = sent_cnt;
			while (sent_cnt - phase_start < PHASE_ITEMS) begin
				if ($urandom_range(0, 3) == 0) begin
					max_gap = 0;
					max_stall = 0;
				end else begin
					max_gap = MAX_IDLE;
					max_stall = MAX_IDLE;
				end
				kind = $urandom_range(0, 9);
				if (kind < 6) begin
					push_table($urandom_range(1, int'(lookahead) + 2), 1'b0);
				end else if (kind < 8) begin
					push_table($urandom_range(1, int'(lookahead) + 2), 1'b1);
				end else begin
					push_noise($urandom_range(0, 20));
				end
			end
		end

		wait_idle();
		repeat (8) @(posedge clk);
		$display("Run covered %0d requests and %0d guesses over %0d lookahead settings.",
			accepted_cnt, checked_cnt, lookahead_writes);
		$display("Winners: pipe %0d, semicolon %0d, comma %0d, tab %0d, space %0d; %0d mismatches.",
			wins[0], wins[1], wins[2], wins[3], wins[4], bad_cnt);
		if (bad_cnt == 0 && guess_q.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/cdg_pkg.sv
rtl/core/cdg_in_if.sv
rtl/core/cdg_out_if.sv
rtl/core/cdg_tracker.sv
rtl/core/csv_delimiter_guesser.sv
dv/tb.sv
